FILE: design/fisheye_point_distortion_macros.svh
// Assertion macros shared by the fisheye distortion checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef FISHEYE_POINT_DISTORTION_MACROS_SVH
`define FISHEYE_POINT_DISTORTION_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define FPD_ASSERT_IMPLY(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("fisheye distortion assertion failed");

// Next-cycle implication, disabled while reset is active.
`define FPD_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("fisheye distortion assertion failed");

`endif

FILE: design/fpd_pkg.sv
// Package for the fisheye point distortion pipeline: widths, register codes,
// the power bundle type and the CORDIC arctangent table. No dependencies.
`default_nettype none

package fpd_pkg;

    localparam int DEF_COORD_WIDTH = 32;
    localparam int DEF_COEF_WIDTH  = 32;

    // Fixed-point formats of the internal datapath.
    localparam int RAD_FRAC   = 24;
    localparam int ANG_FRAC   = 30;
    localparam int Q_WIDTH    = 32;
    localparam int R2_WIDTH   = 64;
    localparam int ROOT_WIDTH = 32;

    // Iteration counts, one pipeline stage each, and the arctangent table length.
    localparam int SQRT_STEPS     = 32;
    localparam int CORDIC_STEPS   = 31;
    localparam int ATAN_TABLE_LEN = 11;
    localparam int DIV_STEPS      = 64;

    // CORDIC vector and angle widths.
    localparam int CXY_WIDTH = 41;
    localparam int Z_WIDTH   = 33;

    // Powers of theta in Q.30.
    localparam int T_W  = 31;
    localparam int T2_W = 32;
    localparam int T3_W = 33;
    localparam int T5_W = 35;
    localparam int T7_W = 36;
    localparam int T9_W = 38;

    // Polynomial terms, theta_d and the scale factor.
    localparam int TERM_MAG_W = 41;
    localparam int TERM_WIDTH = 42;
    localparam int TD_WIDTH   = 45;
    localparam int MTD_WIDTH  = 40;
    localparam int NUM_WIDTH  = 64;
    localparam int CD_WIDTH   = 63;
    localparam int CD_LO_W    = 32;
    localparam int CD_HI_W    = CD_WIDTH - CD_LO_W;

    // Stage numbers: squared radius, root, CORDIC, five power stages, terms,
    // sum, magnitude, divider, scale clamp, two multiply stages and the output register.
    localparam int ST_DIV_END = 3 + SQRT_STEPS + CORDIC_STEPS + 5 + 3 + DIV_STEPS;
    localparam int ST_MUL_END = ST_DIV_END + 3;
    localparam int PIPE_DEPTH = ST_MUL_END + 1;

    localparam int CFG_INDEX_WIDTH = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_K1 = 2'd0,
        REG_K2 = 2'd1,
        REG_K3 = 2'd2,
        REG_K4 = 2'd3
    } cfg_reg_t;

    // Radius and theta powers carried through the power stages.
    typedef struct packed {
        logic [ROOT_WIDTH-1:0] r;
        logic [T_W-1:0]        t;
        logic [T2_W-1:0]       t2;
        logic [T3_W-1:0]       t3;
        logic [T5_W-1:0]       t5;
        logic [T7_W-1:0]       t7;
        logic [T9_W-1:0]       t9;
    } pow_t;

    // Arctangent of 2^-i in Q.30; past the table it equals 2^-i.
    function automatic logic [Z_WIDTH-1:0] atan_step(input int i);
        logic [Z_WIDTH-1:0] a;
        case (i)
            0:       a = Z_WIDTH'(843314857);
            1:       a = Z_WIDTH'(497837829);
            2:       a = Z_WIDTH'(263043837);
            3:       a = Z_WIDTH'(133525159);
            4:       a = Z_WIDTH'(67021687);
            5:       a = Z_WIDTH'(33543516);
            6:       a = Z_WIDTH'(16775851);
            7:       a = Z_WIDTH'(8388437);
            8:       a = Z_WIDTH'(4194283);
            9:       a = Z_WIDTH'(2097149);
            10:      a = Z_WIDTH'(1048576);
            default: a = Z_WIDTH'(64'd1 << (ANG_FRAC - i));
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

FILE: design/fisheye_point_distortion.sv
// Fisheye point distortion, four-coefficient equidistant lens model, as one
// deep pipeline. Depends on fpd_pkg.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  config   | in        | cfg_wr_en            | cfg_index, cfg_data
//  points   | in        | in_valid / in_stall  | point_x, point_y
//  results  | out       | out_valid / out_stall| warped_x, warped_y, clipped
//
// One point enters per cycle unless a stalled result freezes the pipeline.
// Most of the depth is the 32 square-root stages, the 31 CORDIC stages and
// the 64 divider stages, one bit or one rotation per stage.
// Reset clears the valid bits and the coefficients; payload registers hold.
// A stalled result freezes every stage and raises in_stall in that cycle.
`default_nettype none

module fisheye_point_distortion #(
    parameter int COORD_WIDTH = fpd_pkg::DEF_COORD_WIDTH,
    parameter int COEF_WIDTH  = fpd_pkg::DEF_COEF_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [fpd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [COEF_WIDTH-1:0]                cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [COORD_WIDTH-1:0]        point_x,
    input  logic signed [COORD_WIDTH-1:0]        point_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [COORD_WIDTH-1:0]        warped_x,
    output logic signed [COORD_WIDTH-1:0]        warped_y,
    output logic                                 clipped
);
    import fpd_pkg::*;

    localparam int CW         = COORD_WIDTH;
    localparam int KW         = COEF_WIDTH;
    localparam int COORD_FRAC = CW - 8;
    localparam int COEF_FRAC  = KW - 4;
    localparam int FULL_W     = CW + CD_WIDTH;
    localparam int MAG_W      = CW + CD_WIDTH - ANG_FRAC;

    logic adv;
    logic out_vld_reg;

    // The whole pipeline moves unless a finished result is held.
    assign adv      = !(out_vld_reg && out_stall);
    assign in_stall = !adv;

    // Coefficient registers.
    logic [KW-1:0] coef_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_K1:  coef_reg[0] <= cfg_data;
                REG_K2:  coef_reg[1] <= cfg_data;
                REG_K3:  coef_reg[2] <= cfg_data;
                REG_K4:  coef_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Magnitudes of the input coordinates brought to Q.24.
    logic [CW-1:0]      mag_x_c, mag_y_c;
    logic [Q_WIDTH-1:0] qx_c, qy_c;

    assign mag_x_c = point_x[CW-1] ? CW'(~point_x + 1'b1) : CW'(point_x);
    assign mag_y_c = point_y[CW-1] ? CW'(~point_y + 1'b1) : CW'(point_y);

    if (COORD_FRAC >= RAD_FRAC)
    begin : g_qdown
        assign qx_c = Q_WIDTH'(mag_x_c >> (COORD_FRAC - RAD_FRAC));
        assign qy_c = Q_WIDTH'(mag_y_c >> (COORD_FRAC - RAD_FRAC));
    end
    else
    begin : g_qup
        assign qx_c = Q_WIDTH'(Q_WIDTH'(mag_x_c) << (RAD_FRAC - COORD_FRAC));
        assign qy_c = Q_WIDTH'(Q_WIDTH'(mag_y_c) << (RAD_FRAC - COORD_FRAC));
    end

    // Side band: valid bit, original coordinates and the pass-through flag.
    logic          sb_vld_reg  [1:ST_MUL_END];
    logic          sb_pass_reg [1:ST_MUL_END];
    logic [CW-1:0] sb_x_reg    [1:ST_MUL_END];
    logic [CW-1:0] sb_y_reg    [1:ST_MUL_END];

    for (genvar s = 1; s <= ST_MUL_END; s++)
    begin : g_sb
        logic          vld_next, pass_next;
        logic [CW-1:0] x_next, y_next;

        if (s == 1)
        begin : g_head
            assign vld_next  = in_valid;
            assign pass_next = (qx_c == '0) && (qy_c == '0);
            assign x_next    = point_x;
            assign y_next    = point_y;
        end
        else
        begin : g_body
            assign vld_next  = sb_vld_reg[s-1];
            assign pass_next = sb_pass_reg[s-1];
            assign x_next    = sb_x_reg[s-1];
            assign y_next    = sb_y_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sb_vld_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                sb_vld_reg[s] <= vld_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sb_pass_reg[s] <= pass_next;
                sb_x_reg[s]    <= x_next;
                sb_y_reg[s]    <= y_next;
            end
        end
    end

    // Squared radius: magnitudes, squares, sum.
    logic [Q_WIDTH-1:0]  qx_reg, qy_reg;
    logic [R2_WIDTH-1:0] sqx_reg, sqy_reg, r2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qx_reg  <= qx_c;
            qy_reg  <= qy_c;
            sqx_reg <= qx_reg * qx_reg;
            sqy_reg <= qy_reg * qy_reg;
            r2_reg  <= sqx_reg + sqy_reg;
        end
    end

    // Integer square root, one result bit per stage.
    logic [R2_WIDTH-1:0] sq_rem_reg [1:SQRT_STEPS];
    logic [R2_WIDTH-1:0] sq_res_reg [1:SQRT_STEPS];

    for (genvar k = 1; k <= SQRT_STEPS; k++)
    begin : g_sqrt
        logic [R2_WIDTH-1:0] rem_in, res_in, bit_c, trial_c, rem_next, res_next;

        assign bit_c = R2_WIDTH'(1) << (R2_WIDTH - 2 - 2 * (k - 1));

        if (k == 1)
        begin : g_first
            assign rem_in = r2_reg;
            assign res_in = '0;
        end
        else
        begin : g_next
            assign rem_in = sq_rem_reg[k-1];
            assign res_in = sq_res_reg[k-1];
        end

        always_comb
        begin
            trial_c = res_in + bit_c;
            if (rem_in >= trial_c)
            begin
                rem_next = rem_in - trial_c;
                res_next = (res_in >> 1) + bit_c;
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[k] <= rem_next;
                sq_res_reg[k] <= res_next;
            end
        end
    end

    // CORDIC vectoring of (1.0, r): theta = atan(r), one rotation per stage.
    logic signed [CXY_WIDTH-1:0] cx_reg [1:CORDIC_STEPS];
    logic signed [CXY_WIDTH-1:0] cy_reg [1:CORDIC_STEPS];
    logic signed [Z_WIDTH-1:0]   z_reg  [1:CORDIC_STEPS];
    logic [ROOT_WIDTH-1:0]       cr_reg [1:CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        logic signed [CXY_WIDTH-1:0] cx_in, cy_in, dx, dy, cx_next, cy_next;
        logic signed [Z_WIDTH-1:0]   z_in, ang, z_next;
        logic [ROOT_WIDTH-1:0]       r_in;

        if (i == 0)
        begin : g_first
            assign r_in  = sq_res_reg[SQRT_STEPS][ROOT_WIDTH-1:0];
            assign cx_in = CXY_WIDTH'(64'd1 << ANG_FRAC);
            assign cy_in = CXY_WIDTH'(CXY_WIDTH'(r_in) << (ANG_FRAC - RAD_FRAC));
            assign z_in  = '0;
        end
        else
        begin : g_next
            assign r_in  = cr_reg[i];
            assign cx_in = cx_reg[i];
            assign cy_in = cy_reg[i];
            assign z_in  = z_reg[i];
        end

        assign ang = $signed(atan_step(i));
        assign dx  = cy_in >>> i;
        assign dy  = cx_in >>> i;

        always_comb
        begin
            if (!cy_in[CXY_WIDTH-1])
            begin
                cx_next = cx_in + dx;
                cy_next = cy_in - dy;
                z_next  = z_in + ang;
            end
            else
            begin
                cx_next = cx_in - dx;
                cy_next = cy_in + dy;
                z_next  = z_in - ang;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cx_reg[i+1] <= cx_next;
                cy_reg[i+1] <= cy_next;
                z_reg[i+1]  <= z_next;
                cr_reg[i+1] <= r_in;
            end
        end
    end

    // Powers of theta, one product per stage, each truncated to Q.30.
    logic [T_W-1:0]       t_c;
    logic [T_W+T_W-1:0]   m1_c;
    logic [T2_W+T_W-1:0]  m2_c;
    logic [T3_W+T2_W-1:0] m3_c;
    logic [T5_W+T2_W-1:0] m4_c;
    logic [T7_W+T2_W-1:0] m5_c;
    pow_t                 pw1_next, pw2_next, pw3_next, pw4_next, pw5_next;
    pow_t                 pw_reg [1:5];

    assign t_c  = z_reg[CORDIC_STEPS][Z_WIDTH-1] ? '0 : z_reg[CORDIC_STEPS][T_W-1:0];
    assign m1_c = t_c * t_c;
    assign m2_c = pw_reg[1].t2 * pw_reg[1].t;
    assign m3_c = pw_reg[2].t3 * pw_reg[2].t2;
    assign m4_c = pw_reg[3].t5 * pw_reg[3].t2;
    assign m5_c = pw_reg[4].t7 * pw_reg[4].t2;

    always_comb
    begin
        pw1_next    = '0;
        pw1_next.r  = cr_reg[CORDIC_STEPS];
        pw1_next.t  = t_c;
        pw1_next.t2 = T2_W'(m1_c >> ANG_FRAC);
        pw2_next    = pw_reg[1];
        pw2_next.t3 = T3_W'(m2_c >> ANG_FRAC);
        pw3_next    = pw_reg[2];
        pw3_next.t5 = T5_W'(m3_c >> ANG_FRAC);
        pw4_next    = pw_reg[3];
        pw4_next.t7 = T7_W'(m4_c >> ANG_FRAC);
        pw5_next    = pw_reg[4];
        pw5_next.t9 = T9_W'(m5_c >> ANG_FRAC);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pw_reg[1] <= pw1_next;
            pw_reg[2] <= pw2_next;
            pw_reg[3] <= pw3_next;
            pw_reg[4] <= pw4_next;
            pw_reg[5] <= pw5_next;
        end
    end

    // Polynomial terms k_i * theta^n, magnitude truncated toward zero.
    logic [T9_W-1:0]              pow_sel [4];
    logic signed [TERM_WIDTH-1:0] tm_reg  [4];
    logic [T_W-1:0]               tm_t_reg;
    logic [ROOT_WIDTH-1:0]        tm_r_reg;

    assign pow_sel[0] = T9_W'(pw_reg[5].t3);
    assign pow_sel[1] = T9_W'(pw_reg[5].t5);
    assign pow_sel[2] = T9_W'(pw_reg[5].t7);
    assign pow_sel[3] = pw_reg[5].t9;

    for (genvar j = 0; j < 4; j++)
    begin : g_term
        logic [KW-1:0]                km;
        logic [KW+T9_W-1:0]           prod;
        logic [TERM_MAG_W-1:0]        mag;
        logic signed [TERM_WIDTH-1:0] term_next;

        assign km   = coef_reg[j][KW-1] ? KW'(~coef_reg[j] + 1'b1) : coef_reg[j];
        assign prod = km * pow_sel[j];
        assign mag  = TERM_MAG_W'(prod >> COEF_FRAC);
        assign term_next = coef_reg[j][KW-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                tm_reg[j] <= term_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tm_t_reg <= pw_reg[5].t;
            tm_r_reg <= pw_reg[5].r;
        end
    end

    // theta_d as the exact sum of theta and the four terms.
    logic signed [TD_WIDTH-1:0] td_next, td_reg;
    logic [ROOT_WIDTH-1:0]      u_r_reg;

    assign td_next = TD_WIDTH'($signed({1'b0, tm_t_reg}))
                   + TD_WIDTH'(tm_reg[0]) + TD_WIDTH'(tm_reg[1])
                   + TD_WIDTH'(tm_reg[2]) + TD_WIDTH'(tm_reg[3]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            td_reg  <= td_next;
            u_r_reg <= tm_r_reg;
        end
    end

    // Magnitude of theta_d, capped, and the dividend in Q.54.
    logic [TD_WIDTH-1:0]   td_abs_c;
    logic [MTD_WIDTH-1:0]  mtd_c;
    logic [NUM_WIDTH-1:0]  v_num_reg;
    logic                  v_neg_reg;
    logic [ROOT_WIDTH-1:0] v_r_reg;

    assign td_abs_c = td_reg[TD_WIDTH-1] ? TD_WIDTH'(-td_reg) : TD_WIDTH'(td_reg);
    assign mtd_c    = (td_abs_c > TD_WIDTH'({MTD_WIDTH{1'b1}})) ? {MTD_WIDTH{1'b1}}
                                                              : td_abs_c[MTD_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_num_reg <= {mtd_c, {RAD_FRAC{1'b0}}};
            v_neg_reg <= td_reg[TD_WIDTH-1];
            v_r_reg   <= u_r_reg;
        end
    end

    // Restoring divider, one quotient bit per stage; the quotient shifts
    // into the dividend register as the dividend bits shift out.
    logic [NUM_WIDTH-1:0]  dv_num_reg [1:DIV_STEPS];
    logic [ROOT_WIDTH-1:0] dv_rem_reg [1:DIV_STEPS];
    logic [ROOT_WIDTH-1:0] dv_r_reg   [1:DIV_STEPS];
    logic                  dv_neg_reg [1:DIV_STEPS];

    for (genvar d = 1; d <= DIV_STEPS; d++)
    begin : g_div
        logic [NUM_WIDTH-1:0]  num_in;
        logic [ROOT_WIDTH-1:0] rem_in, r_in, rem_next;
        logic                  neg_in, ge;
        logic [ROOT_WIDTH:0]   trial_c, diff_c;

        if (d == 1)
        begin : g_first
            assign num_in = v_num_reg;
            assign rem_in = '0;
            assign r_in   = v_r_reg;
            assign neg_in = v_neg_reg;
        end
        else
        begin : g_next
            assign num_in = dv_num_reg[d-1];
            assign rem_in = dv_rem_reg[d-1];
            assign r_in   = dv_r_reg[d-1];
            assign neg_in = dv_neg_reg[d-1];
        end

        assign trial_c  = {rem_in, num_in[NUM_WIDTH-1]};
        assign diff_c   = trial_c - {1'b0, r_in};
        assign ge       = (trial_c >= {1'b0, r_in});
        assign rem_next = ge ? diff_c[ROOT_WIDTH-1:0] : trial_c[ROOT_WIDTH-1:0];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_num_reg[d] <= {num_in[NUM_WIDTH-2:0], ge};
                dv_rem_reg[d] <= rem_next;
                dv_r_reg[d]   <= r_in;
                dv_neg_reg[d] <= neg_in;
            end
        end
    end

    // Output lanes: scale clamp, split product, shift, saturation.
    localparam logic [CD_WIDTH-1:0] CD_MAX  = CD_WIDTH'(1) << (CD_WIDTH - 1);
    localparam logic [MAG_W-1:0]    POS_MAX = MAG_W'({1'b0, {(CW-1){1'b1}}});
    localparam logic [MAG_W-1:0]    NEG_MAX = MAG_W'(1) << (CW - 1);
    localparam logic [CW-1:0]       OUT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0]       OUT_MIN = {1'b1, {(CW-1){1'b0}}};

    logic [NUM_WIDTH-1:0] quot_c;
    logic [CD_WIDTH-1:0]  cd_c, w_cd_reg;

    assign quot_c = dv_num_reg[DIV_STEPS];
    assign cd_c   = (quot_c > NUM_WIDTH'(CD_MAX)) ? CD_MAX : quot_c[CD_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_cd_reg <= cd_c;
        end
    end

    logic [CW-1:0] lane_in  [2];
    logic [CW-1:0] lane_raw [2];
    logic [CW-1:0] sat_c    [2];
    logic          clip_c   [2];

    assign lane_in[0]  = sb_x_reg[ST_DIV_END];
    assign lane_in[1]  = sb_y_reg[ST_DIV_END];
    assign lane_raw[0] = sb_x_reg[ST_MUL_END];
    assign lane_raw[1] = sb_y_reg[ST_MUL_END];

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [CW-1:0]         mag_in;
        logic [CW-1:0]         w_mag_reg;
        logic                  w_neg_reg, m1_neg_reg, m2_neg_reg;
        logic [CW+CD_LO_W-1:0] p_lo_reg;
        logic [CW+CD_HI_W-1:0] p_hi_reg;
        logic [FULL_W-1:0]     full_c;
        logic [MAG_W-1:0]      m2_mag_reg;

        assign mag_in = lane_in[l][CW-1] ? CW'(~lane_in[l] + 1'b1) : lane_in[l];
        assign full_c = FULL_W'(p_lo_reg) + (FULL_W'(p_hi_reg) << CD_LO_W);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                w_mag_reg  <= mag_in;
                w_neg_reg  <= lane_in[l][CW-1] ^ dv_neg_reg[DIV_STEPS];
                p_lo_reg   <= w_mag_reg * w_cd_reg[CD_LO_W-1:0];
                p_hi_reg   <= w_mag_reg * w_cd_reg[CD_WIDTH-1:CD_LO_W];
                m1_neg_reg <= w_neg_reg;
                m2_mag_reg <= MAG_W'(full_c >> ANG_FRAC);
                m2_neg_reg <= m1_neg_reg;
            end
        end

        // Saturate to the coordinate range; a tiny radius passes through.
        always_comb
        begin
            clip_c[l] = 1'b0;
            if (sb_pass_reg[ST_MUL_END])
            begin
                sat_c[l] = lane_raw[l];
            end
            else if (m2_neg_reg)
            begin
                if (m2_mag_reg > NEG_MAX)
                begin
                    sat_c[l]  = OUT_MIN;
                    clip_c[l] = 1'b1;
                end
                else
                begin
                    sat_c[l] = CW'(MAG_W'(0) - m2_mag_reg);
                end
            end
            else if (m2_mag_reg > POS_MAX)
            begin
                sat_c[l]  = OUT_MAX;
                clip_c[l] = 1'b1;
            end
            else
            begin
                sat_c[l] = CW'(m2_mag_reg);
            end
        end
    end

    // Output register.
    logic [CW-1:0] warped_x_reg, warped_y_reg;
    logic          clipped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= sb_vld_reg[ST_MUL_END];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            warped_x_reg <= sat_c[0];
            warped_y_reg <= sat_c[1];
            clipped_reg  <= clip_c[0] | clip_c[1];
        end
    end

    assign out_valid = out_vld_reg;
    assign warped_x  = warped_x_reg;
    assign warped_y  = warped_y_reg;
    assign clipped   = clipped_reg;

endmodule

`default_nettype wire

FILE: design/fpd_checker.sv
// Port-level checker for the fisheye distortion pipeline and its bind.
// Depends on fpd_pkg and fisheye_point_distortion_macros.svh.
`default_nettype none
`include "fisheye_point_distortion_macros.svh"

module fpd_checker #(
    parameter int COORD_WIDTH = fpd_pkg::DEF_COORD_WIDTH
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_stall,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire logic [COORD_WIDTH-1:0] warped_x,
    input wire logic [COORD_WIDTH-1:0] warped_y,
    input wire logic                   clipped
);
    localparam logic [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // A held result stays valid and unchanged.
    `FPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(warped_x) && $stable(warped_y) && $stable(clipped))

    // The input side stalls only because a result is held at the output.
    `FPD_ASSERT_IMPLY(a_in_stall_src, clk, rst_n, in_stall, out_valid && out_stall)

    // A clipped result has at least one coordinate at a range limit.
    `FPD_ASSERT_IMPLY(a_clip_limit, clk, rst_n, out_valid && clipped, warped_x == MAXV || warped_x == MINV || warped_y == MAXV || warped_y == MINV)

endmodule

bind fisheye_point_distortion fpd_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_fpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .warped_x  (warped_x),
    .warped_y  (warped_y),
    .clipped   (clipped)
);

`default_nettype wire
